/* sv/bole_pkg.sv */
package bole_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int CMD_W    = 3;
	localparam int FIELD_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_AFTER = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_VALUE = 3'd5;
	localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	// What every cell does in one cycle.
	localparam logic [1:0] ACT_HOLD = 2'd0;
	localparam logic [1:0] ACT_INS  = 2'd1;
	localparam logic [1:0] ACT_DEL  = 2'd2;
	localparam logic [1:0] ACT_ROT  = 2'd3;

	// How a cell decides that it lies at or beyond the edit position.
	localparam logic [2:0] SEL_ALL   = 3'd0;
	localparam logic [2:0] SEL_FREE  = 3'd1;
	localparam logic [2:0] SEL_AFTER = 3'd2;
	localparam logic [2:0] SEL_FROM  = 3'd3;
	localparam logic [2:0] SEL_TAIL  = 3'd4;

	typedef struct packed {
		logic       capture;
		logic [1:0] act;
		logic [2:0] sel;
	} cell_ctrl_t;

endpackage

/* sv/bole_cell.sv */
module bole_cell #(
	parameter int DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bole_pkg::cell_ctrl_t    ctrl,
	input  logic [DATA_WIDTH-1:0]   cmp_data,
	input  logic [DATA_WIDTH-1:0]   wr_data,
	input  logic [DATA_WIDTH-1:0]   head_data,
	input  logic [DATA_WIDTH-1:0]   left_data,
	input  logic                    left_valid,
	input  logic                    left_sel,
	input  logic [DATA_WIDTH-1:0]   right_data,
	input  logic                    right_valid,
	input  logic                    hit_in,
	output logic [DATA_WIDTH-1:0]   data,
	output logic                    valid,
	output logic                    sel,
	output logic                    hit_out
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  valid_q;
	logic                  match_q;

	assign data    = data_q;
	assign valid   = valid_q;
	assign hit_out = hit_in | match_q;

	always_comb begin
		case (ctrl.sel)
			bole_pkg::SEL_ALL:   sel = 1'b1;
			bole_pkg::SEL_FREE:  sel = ~valid_q;
			bole_pkg::SEL_AFTER: sel = hit_in;
			bole_pkg::SEL_FROM:  sel = hit_in | match_q;
			bole_pkg::SEL_TAIL:  sel = ~right_valid;
			default:             sel = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.capture) begin
				match_q <= valid_q && (data_q == cmp_data);
			end
			case (ctrl.act)
				bole_pkg::ACT_INS: begin
					if (left_sel) begin
						valid_q <= left_valid;
					end else if (sel) begin
						valid_q <= 1'b1;
					end
				end
				bole_pkg::ACT_DEL: begin
					if (sel) begin
						valid_q <= right_valid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.act)
			bole_pkg::ACT_INS: begin
				if (left_sel) begin
					data_q <= left_data;
				end else if (sel) begin
					data_q <= wr_data;
				end
			end
			bole_pkg::ACT_DEL: begin
				if (sel) begin
					data_q <= right_data;
				end
			end
			bole_pkg::ACT_ROT: begin
				// The last occupied cell wraps round to the head, so the list rotates.
				data_q <= right_valid ? right_data : head_data;
			end
			default: begin
			end
		endcase
	end

endmodule

/* sv/bounded_ordered_list_engine.sv */
// Ordered list of up to CAPACITY signed entries held in a chain of cells, entry 0 at the front.
// A command is taken when start is high and busy is low; busy then stays high while the cells
// capture their key compare and then shift, and the single result strobes on done in the cycle
// after, with busy low again and a new command able to be taken. A dump keeps busy high while
// the chain rotates once per entry, and strobes one result per entry on consecutive cycles,
// front first, with last on the final one; the chain is back in order at the end.
// Results cannot be stalled: each is valid for exactly the one cycle that done is high.
module bounded_ordered_list_engine #(
	parameter int CAPACITY   = bole_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [bole_pkg::CMD_W-1:0]            cmd,
	input  logic signed [bole_pkg::FIELD_W-1:0]   value,
	input  logic signed [bole_pkg::FIELD_W-1:0]   key,
	output logic                                  done,
	output logic [bole_pkg::STATUS_W-1:0]         status,
	output logic signed [bole_pkg::FIELD_W-1:0]   item,
	output logic [bole_pkg::COUNT_W-1:0]          count,
	output logic                                  last
);

	localparam int CW      = $clog2(CAPACITY + 1);
	localparam int FIELD_W = bole_pkg::FIELD_W;
	localparam int COUNT_W = bole_pkg::COUNT_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MATCH = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;
	localparam logic [1:0] S_DUMP  = 2'd3;

	logic [1:0]                    state_q;
	logic [bole_pkg::CMD_W-1:0]    cmd_q;
	logic signed [DATA_WIDTH-1:0]  value_q;
	logic signed [DATA_WIDTH-1:0]  key_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 idx_q;

	logic                          done_q;
	logic [bole_pkg::STATUS_W-1:0] status_q;
	logic signed [FIELD_W-1:0]     item_q;
	logic [CW-1:0]                 rcount_q;
	logic                          last_q;

	bole_pkg::cell_ctrl_t          ctrl;
	logic [bole_pkg::STATUS_W-1:0] apply_status;
	logic [CW-1:0]                 apply_cnt;
	logic [DATA_WIDTH-1:0]         cmp_data;

	logic [DATA_WIDTH-1:0]         cell_data [CAPACITY];
	logic [CAPACITY-1:0]           valid_vec;
	logic [CAPACITY-1:0]           sel_vec;
	logic [CAPACITY:0]             hit;

	logic                          full;
	logic                          empty;
	logic                          found;
	logic                          dump_last;

	assign busy      = (state_q != S_IDLE);
	assign full      = (cnt_q == CW'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign found     = hit[CAPACITY];
	assign dump_last = (CW'(idx_q + 1'b1) == cnt_q);
	assign cmp_data  = (cmd_q == bole_pkg::CMD_DEL_VALUE) ? value_q : key_q;
	assign hit[0]    = 1'b0;

	assign done   = done_q;
	assign status = status_q;
	assign item   = item_q;
	assign count  = COUNT_W'(rcount_q);
	assign last   = last_q;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [DATA_WIDTH-1:0] left_data;
			logic                  left_valid;
			logic                  left_sel;
			logic [DATA_WIDTH-1:0] right_data;
			logic                  right_valid;

			if (g == 0) begin : g_first
				assign left_data  = value_q;
				assign left_valid = 1'b0;
				assign left_sel   = 1'b0;
			end else begin : g_mid
				assign left_data  = cell_data[g-1];
				assign left_valid = valid_vec[g-1];
				assign left_sel   = sel_vec[g-1];
			end

			if (g == CAPACITY - 1) begin : g_end
				assign right_data  = '0;
				assign right_valid = 1'b0;
			end else begin : g_inner
				assign right_data  = cell_data[g+1];
				assign right_valid = valid_vec[g+1];
			end

			bole_cell #(
				.DATA_WIDTH (DATA_WIDTH)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.cmp_data    (cmp_data),
				.wr_data     (value_q),
				.head_data   (cell_data[0]),
				.left_data   (left_data),
				.left_valid  (left_valid),
				.left_sel    (left_sel),
				.right_data  (right_data),
				.right_valid (right_valid),
				.hit_in      (hit[g]),
				.data        (cell_data[g]),
				.valid       (valid_vec[g]),
				.sel         (sel_vec[g]),
				.hit_out     (hit[g+1])
			);
		end
	endgenerate

	// Decide the edit for the update cycle from the captured matches; the match state captures and the dump state rotates.
	always_comb begin
		ctrl         = '{capture: 1'b0, act: bole_pkg::ACT_HOLD, sel: bole_pkg::SEL_ALL};
		apply_status = bole_pkg::ST_OK;
		apply_cnt    = cnt_q;
		case (state_q)
			S_MATCH: begin
				ctrl.capture = 1'b1;
			end
			S_DUMP: begin
				ctrl.act = bole_pkg::ACT_ROT;
			end
			S_APPLY: begin
				case (cmd_q)
					bole_pkg::CMD_INS_FRONT, bole_pkg::CMD_INS_BACK,
					bole_pkg::CMD_INS_AFTER: begin
						if (full) begin
							apply_status = bole_pkg::ST_FULL;
						end else if (cmd_q == bole_pkg::CMD_INS_FRONT || empty) begin
							ctrl.act  = bole_pkg::ACT_INS;
							ctrl.sel  = bole_pkg::SEL_ALL;
							apply_cnt = CW'(cnt_q + 1'b1);
						end else if (cmd_q == bole_pkg::CMD_INS_BACK) begin
							ctrl.act  = bole_pkg::ACT_INS;
							ctrl.sel  = bole_pkg::SEL_FREE;
							apply_cnt = CW'(cnt_q + 1'b1);
						end else if (found) begin
							ctrl.act  = bole_pkg::ACT_INS;
							ctrl.sel  = bole_pkg::SEL_AFTER;
							apply_cnt = CW'(cnt_q + 1'b1);
						end else begin
							apply_status = bole_pkg::ST_NOT_FOUND;
						end
					end
					bole_pkg::CMD_DEL_FRONT, bole_pkg::CMD_DEL_BACK: begin
						if (empty) begin
							apply_status = bole_pkg::ST_EMPTY;
						end else begin
							ctrl.act  = bole_pkg::ACT_DEL;
							ctrl.sel  = (cmd_q == bole_pkg::CMD_DEL_FRONT) ?
								bole_pkg::SEL_ALL : bole_pkg::SEL_TAIL;
							apply_cnt = CW'(cnt_q - 1'b1);
						end
					end
					bole_pkg::CMD_DEL_VALUE: begin
						if (empty) begin
							apply_status = bole_pkg::ST_EMPTY;
						end else if (found) begin
							ctrl.act  = bole_pkg::ACT_DEL;
							ctrl.sel  = bole_pkg::SEL_FROM;
							apply_cnt = CW'(cnt_q - 1'b1);
						end else begin
							apply_status = bole_pkg::ST_NOT_FOUND;
						end
					end
					bole_pkg::CMD_DUMP: begin
						if (empty) begin
							apply_status = bole_pkg::ST_EMPTY;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					idx_q <= '0;
					if (cmd_q == bole_pkg::CMD_DUMP && !empty) begin
						state_q <= S_DUMP;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						cnt_q   <= apply_cnt;
					end
				end
				S_DUMP: begin
					done_q <= 1'b1;
					idx_q  <= CW'(idx_q + 1'b1);
					if (dump_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q   <= cmd;
			value_q <= DATA_WIDTH'(value);
			key_q   <= DATA_WIDTH'(key);
		end
		if (state_q == S_APPLY) begin
			status_q <= apply_status;
			item_q   <= '0;
			rcount_q <= apply_cnt;
			last_q   <= 1'b1;
		end else if (state_q == S_DUMP) begin
			// The head cell always holds the next entry while the chain rotates.
			status_q <= bole_pkg::ST_OK;
			item_q   <= FIELD_W'(signed'(cell_data[0]));
			rcount_q <= cnt_q;
			last_q   <= dump_last;
		end
	end

`ifndef SYNTHESIS
	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == cnt_q)
		else $error("occupied cells disagree with the entry count");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_transfer_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command transfer did not raise busy");

	a_dump_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("gap inside a run of dump results");

	a_one_result_per_command: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result appeared in the cycle after a transfer");
`endif

endmodule

/* tb/sv/bounded_ordered_list_engine_tb.sv */
`timescale 1ns / 1ps

module bounded_ordered_list_engine_tb;

	// Code 7 has no operation assigned; the block answers it with a plain ok.
	localparam logic [bole_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct packed {
		logic [bole_pkg::STATUS_W-1:0]       status;
		logic signed [bole_pkg::FIELD_W-1:0] item;
		logic [bole_pkg::COUNT_W-1:0]        count;
		logic                                last;
	} list_reply_t;

	class list_scoreboard;
		logic signed [bole_pkg::FIELD_W-1:0] entries[$];
		list_reply_t                         pending_replies[$];
		int unsigned                         fail_count;
		int                                  capacity;

		function new(int cap);
			capacity   = cap;
			fail_count = 0;
		endfunction

		function int find_entry(logic signed [bole_pkg::FIELD_W-1:0] v);
			foreach (entries[i])
				if (entries[i] == v)
					return i;
			return -1;
		endfunction

		function void push_reply(logic [bole_pkg::STATUS_W-1:0] st,
				logic signed [bole_pkg::FIELD_W-1:0] itm, logic lst);
			list_reply_t r;
			r.status = st;
			r.item   = itm;
			r.count  = bole_pkg::COUNT_W'(entries.size());
			r.last   = lst;
			pending_replies.push_back(r);
		endfunction

		// Applies one accepted command to the list and queues the replies it must produce.
		function void note_command(logic [bole_pkg::CMD_W-1:0] c,
				logic signed [bole_pkg::FIELD_W-1:0] v,
				logic signed [bole_pkg::FIELD_W-1:0] k);
			logic [bole_pkg::STATUS_W-1:0] st;
			int                            pos;
			st = bole_pkg::ST_OK;
			case (c)
				bole_pkg::CMD_INS_FRONT, bole_pkg::CMD_INS_BACK,
				bole_pkg::CMD_INS_AFTER: begin
					if (entries.size() >= capacity)
						st = bole_pkg::ST_FULL;
					else if (c == bole_pkg::CMD_INS_FRONT || entries.size() == 0)
						entries.push_front(v);
					else if (c == bole_pkg::CMD_INS_BACK)
						entries.push_back(v);
					else begin
						pos = find_entry(k);
						if (pos < 0)
							st = bole_pkg::ST_NOT_FOUND;
						else
							entries.insert(pos + 1, v);
					end
				end
				bole_pkg::CMD_DEL_FRONT, bole_pkg::CMD_DEL_BACK: begin
					if (entries.size() == 0)
						st = bole_pkg::ST_EMPTY;
					else if (c == bole_pkg::CMD_DEL_FRONT)
						void'(entries.pop_front());
					else
						void'(entries.pop_back());
				end
				bole_pkg::CMD_DEL_VALUE: begin
					if (entries.size() == 0)
						st = bole_pkg::ST_EMPTY;
					else begin
						pos = find_entry(v);
						if (pos < 0)
							st = bole_pkg::ST_NOT_FOUND;
						else
							entries.delete(pos);
					end
				end
				bole_pkg::CMD_DUMP: begin
					if (entries.size() == 0)
						push_reply(bole_pkg::ST_EMPTY, '0, 1'b1);
					else
						foreach (entries[i])
							push_reply(bole_pkg::ST_OK, entries[i],
								i == entries.size() - 1);
					return;
				end
				default: ;
			endcase
			push_reply(st, '0, 1'b1);
		endfunction

		function void check_result(logic [bole_pkg::STATUS_W-1:0] st,
				logic signed [bole_pkg::FIELD_W-1:0] itm,
				logic [bole_pkg::COUNT_W-1:0] cnt, logic lst);
			list_reply_t exp_r;
			if (pending_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected result: status %0d item %0d count %0d last %0b",
						$time, st, itm, cnt, lst);
				return;
			end
			exp_r = pending_replies.pop_front();
			if (exp_r.status !== st || exp_r.item !== itm || exp_r.count !== cnt ||
					exp_r.last !== lst) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: status item count last: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
						$time, exp_r.status, exp_r.item, exp_r.count, exp_r.last,
						st, itm, cnt, lst);
			end
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic [bole_pkg::CMD_W-1:0]          cmd;
	logic signed [bole_pkg::FIELD_W-1:0] value;
	logic signed [bole_pkg::FIELD_W-1:0] key;
	logic                                done;
	logic [bole_pkg::STATUS_W-1:0]       status;
	logic signed [bole_pkg::FIELD_W-1:0] item;
	logic [bole_pkg::COUNT_W-1:0]        count;
	logic                                last;

	list_scoreboard                      sb;
	logic signed [bole_pkg::FIELD_W-1:0] value_pool[8];
	int                                  stall_cycles;

	bounded_ordered_list_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.value  (value),
		.key    (key),
		.done   (done),
		.status (status),
		.item   (item),
		.count  (count),
		.last   (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Results come first so that a reply landing on the same edge as a new transfer
	// is matched against the replies already queued.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(status, item, count, last);
			if (start && !busy)
				sb.note_command(cmd, value, key);
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("bounded_ordered_list_engine_tb: done, errors");
				$finish;
			end else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// Start stays high until the edge at which busy is low, which is the transfer edge.
	task automatic send_command(input logic [bole_pkg::CMD_W-1:0] c,
			input logic signed [bole_pkg::FIELD_W-1:0] v,
			input logic signed [bole_pkg::FIELD_W-1:0] k, input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		cmd   <= c;
		value <= v;
		key   <= k;
		do
			@(posedge clk);
		while (busy);
	endtask

	function automatic logic signed [bole_pkg::FIELD_W-1:0] pick_value();
		if ($urandom_range(99) < 55)
			return value_pool[$urandom_range(7)];
		return $urandom;
	endfunction

	// The insert share swings between high and low every thirty commands so that the list
	// keeps travelling between empty and full.
	task automatic run_random(input int n, input int idle_pct);
		logic [bole_pkg::CMD_W-1:0]          c;
		logic signed [bole_pkg::FIELD_W-1:0] v;
		logic signed [bole_pkg::FIELD_W-1:0] k;
		int                                  insert_pct;
		int                                  r;
		for (int i = 0; i < n; i++) begin
			insert_pct = ((i / 30) % 2 == 0) ? 80 : 20;
			r = $urandom_range(99);
			if (r < 12)
				c = bole_pkg::CMD_DUMP;
			else if (r < 15)
				c = CMD_UNUSED;
			else if ($urandom_range(99) < insert_pct) begin
				case ($urandom_range(2))
					0: c = bole_pkg::CMD_INS_FRONT;
					1: c = bole_pkg::CMD_INS_BACK;
					default: c = bole_pkg::CMD_INS_AFTER;
				endcase
			end else begin
				case ($urandom_range(2))
					0: c = bole_pkg::CMD_DEL_FRONT;
					1: c = bole_pkg::CMD_DEL_BACK;
					default: c = bole_pkg::CMD_DEL_VALUE;
				endcase
			end
			v = pick_value();
			k = pick_value();
			send_command(c, v, k, idle_pct);
			// Fresh values go into the pool so later keys and deletes can hit them.
			if (c == bole_pkg::CMD_INS_FRONT || c == bole_pkg::CMD_INS_BACK ||
					c == bole_pkg::CMD_INS_AFTER)
				value_pool[4 + $urandom_range(3)] = v;
		end
	endtask

	initial begin
		start        = 1'b0;
		cmd          = bole_pkg::CMD_INS_FRONT;
		value        = '0;
		key          = '0;
		arst_n       = 1'b0;
		stall_cycles = 0;
		sb           = new(bole_pkg::CAPACITY_DEF);
		value_pool[0] = 32'sh0000_0000;
		value_pool[1] = -32'sd1;
		value_pool[2] = 32'sh8000_0000;
		value_pool[3] = 32'sh7FFF_FFFF;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Dumps, deletes and an insert after a key, each on an empty list.
		send_command(bole_pkg::CMD_DUMP, '0, '0, 0);
		send_command(bole_pkg::CMD_DEL_FRONT, '0, '0, 0);
		send_command(bole_pkg::CMD_DEL_BACK, '0, '0, 0);
		send_command(bole_pkg::CMD_DEL_VALUE, 32'sh7FFF_FFFF, '0, 0);
		send_command(bole_pkg::CMD_INS_AFTER, 32'sh7FFF_FFFF, 32'sh1234_5678, 0);
		send_command(bole_pkg::CMD_INS_FRONT, 32'sh8000_0000, '0, 0);
		send_command(bole_pkg::CMD_INS_BACK, -32'sd1, '0, 0);
		// The key is the final entry, so this appends.
		send_command(bole_pkg::CMD_INS_AFTER, 32'sh0000_0000, -32'sd1, 0);
		send_command(bole_pkg::CMD_INS_AFTER, 32'sh5555_5555, 32'sh8000_0000, 0);
		send_command(bole_pkg::CMD_INS_AFTER, 32'sh2AAA_AAAA, 32'sd12345, 0);
		send_command(bole_pkg::CMD_DEL_VALUE, 32'sh2AAA_AAAA, '0, 0);
		// A duplicate at the front: deleting by value must remove only the front copy.
		send_command(bole_pkg::CMD_INS_FRONT, -32'sd1, '0, 0);
		send_command(bole_pkg::CMD_DEL_VALUE, -32'sd1, '0, 0);
		send_command(CMD_UNUSED, $urandom, $urandom, 0);
		send_command(bole_pkg::CMD_DUMP, '0, '0, 0);
		// Five entries are held now; fill to capacity, then try each insert on a full list.
		for (int i = 0; i < bole_pkg::CAPACITY_DEF - 5; i++)
			send_command((i % 2 == 0) ? bole_pkg::CMD_INS_BACK : bole_pkg::CMD_INS_FRONT,
				$urandom, '0, 0);
		send_command(bole_pkg::CMD_INS_FRONT, 32'sd7, '0, 0);
		send_command(bole_pkg::CMD_INS_BACK, 32'sd7, '0, 0);
		send_command(bole_pkg::CMD_INS_AFTER, 32'sd7, 32'sh8000_0000, 0);
		send_command(bole_pkg::CMD_DUMP, '0, '0, 0);
		send_command(bole_pkg::CMD_DEL_FRONT, '0, '0, 0);

		run_random(47, 9);
		run_random(47, 67);
		run_random(45, 0);
		start <= 1'b0;

		while (sb.pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (sb.fail_count == 0 && sb.pending_replies.size() == 0)
			$display("bounded_ordered_list_engine_tb: done, clean");
		else
			$display("bounded_ordered_list_engine_tb: done, errors");
		$finish;
	end

endmodule

/* files.f */
sv/bole_pkg.sv
sv/bole_cell.sv
sv/bounded_ordered_list_engine.sv
tb/sv/bounded_ordered_list_engine_tb.sv
